[src/dshot_frame_waveform_encoder_defines.svh]
// assertion macros shared by the encoder checker
// no dependencies; included by the checker file only
`ifndef DSHOT_FRAME_WAVEFORM_ENCODER_DEFINES_SVH
`define DSHOT_FRAME_WAVEFORM_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DFWE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dfwe check failed");

// next-cycle implication, disabled while reset is low
`define DFWE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dfwe check failed");

`endif

[src/dfwe_pkg.sv]
// types, constants and the frame builder of the dshot waveform encoder
// no dependencies
package dfwe_pkg;

	localparam int THROTTLE_W = 11;
	localparam int FRAME_BITS = 16;
	localparam int PIN_FIELDS = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef logic [THROTTLE_W-1:0] throttle_t;
	typedef logic [FRAME_BITS-1:0] frame_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLES_PER_BIT   = 3'd0,
		CFG_SAMPLES_HIGH_ONE  = 3'd1,
		CFG_SAMPLES_HIGH_ZERO = 3'd2,
		CFG_GAP_SAMPLES       = 3'd3,
		CFG_TELEMETRY_REQUEST = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0] samples_per_bit;
		logic [3:0] samples_high_one;
		logic [3:0] samples_high_zero;
		logic [7:0] gap_samples;
		logic       telemetry_request;
	} cfg_t;

	// throttle, telemetry bit, then xor of the three nibbles above
	function automatic frame_t build_frame(input throttle_t thr, input logic tel);
		logic [11:0] word;
		logic [3:0]  csum;
		word = {thr, tel};
		csum = word[3:0] ^ word[7:4] ^ word[11:8];
		return {word, csum};
	endfunction

endpackage

[src/dfwe_in_if.sv]
// input channel of the encoder: valid, ready, command and four throttles
// depends on dfwe_pkg
interface dfwe_in_if;
	import dfwe_pkg::*;

	logic      valid;
	logic      ready;
	logic      func;
	throttle_t throttle_0;
	throttle_t throttle_1;
	throttle_t throttle_2;
	throttle_t throttle_3;

	modport source (output valid, func, throttle_0, throttle_1, throttle_2, throttle_3,
		input ready);
	modport sink (input valid, func, throttle_0, throttle_1, throttle_2, throttle_3,
		output ready);
endinterface

[src/dfwe_out_if.sv]
// result channel of the encoder: valid, ready, pin levels and status
// depends on dfwe_pkg
interface dfwe_out_if;
	import dfwe_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIN_FIELDS-1:0] pin_levels;
	logic                  active;
	logic                  done_res;

	modport source (output valid, pin_levels, active, done_res, input ready);
	modport sink (input valid, pin_levels, active, done_res, output ready);
endinterface

[src/dfwe_in_stage.sv]
// input register stage of the encoder
// depends on dfwe_pkg
module dfwe_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  dfwe_pkg::throttle_t throttle [dfwe_pkg::PIN_FIELDS],
	input  logic                take,
	output logic                valid_s1,
	output logic                func_s1,
	output dfwe_pkg::throttle_t throttle_s1 [dfwe_pkg::PIN_FIELDS]
);
	import dfwe_pkg::*;

	logic load;

	// stage frees up when its item moves on to the result register
	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			func_s1     <= func;
			throttle_s1 <= throttle;
		end
	end
endmodule

[src/dfwe_core.sv]
// frame state, per-sample pin logic and result register of the encoder
// depends on dfwe_pkg
module dfwe_core #(
	parameter int MOTORS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dfwe_pkg::cfg_t                    cfg,
	input  logic                              valid_s1,
	input  logic                              func_s1,
	input  dfwe_pkg::throttle_t               throttle_s1 [dfwe_pkg::PIN_FIELDS],
	output logic                              take,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [dfwe_pkg::PIN_FIELDS-1:0]   pin_levels,
	output logic                              active,
	output logic                              done_res
);
	import dfwe_pkg::*;

	frame_t     frame_q [MOTORS];
	logic [4:0] bit_q;
	logic [3:0] samp_q;
	logic [7:0] gap_q;
	logic       busy_q;

	frame_t     frame_d [MOTORS];
	frame_t     start_frame [MOTORS];
	logic [4:0] bit_d;
	logic [3:0] samp_d;
	logic [7:0] gap_d;
	logic       busy_d;

	logic [MOTORS-1:0]     pins_all;
	logic [PIN_FIELDS-1:0] pins_sel;
	logic [PIN_FIELDS-1:0] pins_d;
	logic                  act_d;
	logic                  done_d;

	logic [3:0] per_bit;
	logic [3:0] samp_inc;
	logic [4:0] bit_inc;
	logic [7:0] gap_inc;
	logic       in_frame;
	logic       bit_end;

	logic       res_valid_q;
	logic [PIN_FIELDS-1:0] pins_q;
	logic       act_q;
	logic       done_q;

	assign take = valid_s1 && (!res_valid_q || res_ready);

	// motors past the throttle fields run on a zero throttle
	for (genvar m = 0; m < MOTORS; m++) begin : g_motor
		if (m < PIN_FIELDS) begin : g_fed
			assign start_frame[m] = build_frame(throttle_s1[m], cfg.telemetry_request);
		end else begin : g_zero
			assign start_frame[m] = build_frame('0, cfg.telemetry_request);
		end
		assign pins_all[m] = frame_q[m][FRAME_BITS-1] ? (samp_q < cfg.samples_high_one)
			: (samp_q < cfg.samples_high_zero);
	end

	for (genvar p = 0; p < PIN_FIELDS; p++) begin : g_pin
		if (p < MOTORS) begin : g_drv
			assign pins_sel[p] = pins_all[p];
		end else begin : g_off
			assign pins_sel[p] = 1'b0;
		end
	end

	assign per_bit  = (cfg.samples_per_bit == 4'd0) ? 4'd1 : cfg.samples_per_bit;
	assign samp_inc = samp_q + 4'd1;
	assign bit_inc  = bit_q + 5'd1;
	assign gap_inc  = gap_q + 8'd1;
	assign in_frame = bit_q < 5'(FRAME_BITS);
	assign bit_end  = samp_inc >= per_bit;

	always_comb begin
		frame_d = frame_q;
		bit_d   = bit_q;
		samp_d  = samp_q;
		gap_d   = gap_q;
		busy_d  = busy_q;
		pins_d  = '0;
		act_d   = 1'b0;
		done_d  = 1'b0;
		if (!func_s1) begin
			// a start always restarts, even mid-frame
			frame_d = start_frame;
			bit_d   = '0;
			samp_d  = '0;
			gap_d   = '0;
			busy_d  = 1'b1;
			act_d   = 1'b1;
		end else if (busy_q) begin
			act_d = 1'b1;
			if (in_frame) begin
				pins_d = pins_sel;
				samp_d = samp_inc;
				if (bit_end) begin
					samp_d = '0;
					for (int m = 0; m < MOTORS; m++) begin
						frame_d[m] = {frame_q[m][FRAME_BITS-2:0], 1'b0};
					end
					bit_d = bit_inc;
					// no gap: last bit sample also closes the frame
					if (bit_inc >= 5'(FRAME_BITS) && cfg.gap_samples == 8'd0) begin
						done_d = 1'b1;
						busy_d = 1'b0;
					end
				end
			end else begin
				gap_d = gap_inc;
				if (gap_inc >= cfg.gap_samples) begin
					done_d = 1'b1;
					busy_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTORS; m++) begin
				frame_q[m] <= '0;
			end
			bit_q       <= '0;
			samp_q      <= '0;
			gap_q       <= '0;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				frame_q <= frame_d;
				bit_q   <= bit_d;
				samp_q  <= samp_d;
				gap_q   <= gap_d;
				busy_q  <= busy_d;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pins_q <= pins_d;
			act_q  <= act_d;
			done_q <= done_d;
		end
	end

	assign res_valid  = res_valid_q;
	assign pin_levels = pins_q;
	assign active     = act_q;
	assign done_res   = done_q;
endmodule

[src/dshot_frame_waveform_encoder.sv]
// dshot frame waveform encoder: start items load per-motor frames, tick items emit one sample
// path: each item passes the input register and then the result register before its result transfers
// throughput: one item per cycle while results are taken; a stalled result holds one item in the input register
// the frame state is updated in the single pass between the two registers
// reset: configuration returns to 8/6/3 samples, gap 16, telemetry off; encoder idle
// depends on dfwe_pkg, dfwe_in_if, dfwe_out_if, dfwe_in_stage, dfwe_core
module dshot_frame_waveform_encoder #(
	parameter int MOTORS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dfwe_in_if.sink                           item,
	dfwe_out_if.source                        result,
	input  logic                              cfg_wr_en,
	input  logic [dfwe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfwe_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dfwe_pkg::*;

	cfg_t      cfg_q;
	throttle_t throttle [PIN_FIELDS];
	throttle_t throttle_s1 [PIN_FIELDS];
	logic      valid_s1;
	logic      func_s1;
	logic      take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_bit   <= 4'd8;
			cfg_q.samples_high_one  <= 4'd6;
			cfg_q.samples_high_zero <= 4'd3;
			cfg_q.gap_samples       <= 8'd16;
			cfg_q.telemetry_request <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SAMPLES_PER_BIT:   cfg_q.samples_per_bit   <= cfg_data[3:0];
				CFG_SAMPLES_HIGH_ONE:  cfg_q.samples_high_one  <= cfg_data[3:0];
				CFG_SAMPLES_HIGH_ZERO: cfg_q.samples_high_zero <= cfg_data[3:0];
				CFG_GAP_SAMPLES:       cfg_q.gap_samples       <= cfg_data;
				CFG_TELEMETRY_REQUEST: cfg_q.telemetry_request <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign throttle[0] = item.throttle_0;
	assign throttle[1] = item.throttle_1;
	assign throttle[2] = item.throttle_2;
	assign throttle[3] = item.throttle_3;

	dfwe_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (item.valid),
		.in_ready    (item.ready),
		.func        (item.func),
		.throttle    (throttle),
		.take        (take),
		.valid_s1    (valid_s1),
		.func_s1     (func_s1),
		.throttle_s1 (throttle_s1)
	);

	dfwe_core #(
		.MOTORS (MOTORS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.valid_s1    (valid_s1),
		.func_s1     (func_s1),
		.throttle_s1 (throttle_s1),
		.take        (take),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.pin_levels  (result.pin_levels),
		.active      (result.active),
		.done_res    (result.done_res)
	);
endmodule

[src/dfwe_checker.sv]
// port-level checks on the encoder result channel, bound to the top level
// depends on dshot_frame_waveform_encoder_defines.svh and dfwe_pkg
`include "dshot_frame_waveform_encoder_defines.svh"

module dfwe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [dfwe_pkg::PIN_FIELDS-1:0] pin_levels,
	input logic                            active,
	input logic                            done_res
);
	import dfwe_pkg::*;

	// a finished frame is only reported while it is still marked active
	`DFWE_ASSERT_IMP(a_done_active, clk, arst_n, res_valid && done_res, active)
	// no pin is driven high outside a frame
	`DFWE_ASSERT_IMP(a_pins_active, clk, arst_n, res_valid && pin_levels != '0, active)
	// a stalled result keeps its contents
	`DFWE_ASSERT_NXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(pin_levels) && $stable(active) && $stable(done_res))
endmodule

bind dshot_frame_waveform_encoder dfwe_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.pin_levels (result.pin_levels),
	.active     (result.active),
	.done_res   (result.done_res)
);

[tb/dfwe_tb_pkg.sv]
// item command codes shared by the encoder testbench and its checker
// no dependencies
package dfwe_tb_pkg;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_TICK  = 1'b1
	} func_t;

endpackage

[tb/dfwe_checker.sv]
// checker of the dshot waveform encoder: tracks register writes, predicts one sample per
// input transfer and compares each result transfer; depends on dfwe_pkg, dfwe_tb_pkg, interfaces
module dfwe_scoreboard (
	input  logic       clk,
	input  logic       arst_n,
	dfwe_in_if         item,
	dfwe_out_if        result,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fails,
	output int         waiting
);
	import dfwe_pkg::*;
	import dfwe_tb_pkg::*;

	typedef struct packed {
		logic [3:0] pins;
		logic       active;
		logic       done;
	} pin_sample_t;

	cfg_t          regs;
	logic [15:0]   frame_q [4];
	logic [4:0]    bits_sent;
	logic [3:0]    sample_pos;
	logic [7:0]    gap_sent;
	logic          sending;
	pin_sample_t   sample_q [$];
	pin_sample_t   want_s;

	function automatic logic [15:0] dshot_word(input logic [10:0] thr, input logic tel);
		logic [15:0] w;
		logic [3:0]  crc;
		w = {thr, tel, 4'b0000};
		crc = 4'b0000;
		for (int n = 1; n < 4; n++)
			crc = crc ^ w[n*4 +: 4];
		return w | {12'b0, crc};
	endfunction

	function automatic pin_sample_t encode_step(input logic func, input logic [3:0][10:0] thr);
		pin_sample_t s;
		logic [3:0]  span;
		logic [3:0]  hi;
		s = '0;
		if (func == FUNC_START) begin
			for (int m = 0; m < 4; m++)
				frame_q[m] = dshot_word(thr[m], regs.telemetry_request);
			bits_sent = '0;
			sample_pos = '0;
			gap_sent = '0;
			sending = 1'b1;
			s.active = 1'b1;
		end else if (sending) begin
			s.active = 1'b1;
			if (bits_sent < FRAME_BITS) begin
				// a zero bit length still takes one sample
				span = (regs.samples_per_bit == 4'd0) ? 4'd1 : regs.samples_per_bit;
				for (int m = 0; m < 4; m++) begin
					hi = frame_q[m][15] ? regs.samples_high_one : regs.samples_high_zero;
					if (sample_pos < hi)
						s.pins[m] = 1'b1;
				end
				sample_pos = sample_pos + 4'd1;
				if (sample_pos >= span) begin
					sample_pos = '0;
					for (int m = 0; m < 4; m++)
						frame_q[m] = frame_q[m] << 1;
					bits_sent = bits_sent + 5'd1;
					// no gap: the last bit sample also ends the frame
					if (bits_sent >= FRAME_BITS && regs.gap_samples == 8'd0) begin
						s.done = 1'b1;
						sending = 1'b0;
					end
				end
			end else begin
				gap_sent = gap_sent + 8'd1;
				if (gap_sent >= regs.gap_samples) begin
					s.done = 1'b1;
					sending = 1'b0;
				end
			end
		end
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fails = fails + 1;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.samples_per_bit = 4'd8;
			regs.samples_high_one = 4'd6;
			regs.samples_high_zero = 4'd3;
			regs.gap_samples = 8'd16;
			regs.telemetry_request = 1'b0;
			for (int m = 0; m < 4; m++)
				frame_q[m] = '0;
			bits_sent = '0;
			sample_pos = '0;
			gap_sent = '0;
			sending = 1'b0;
			sample_q.delete();
			fails = 0;
			waiting = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SAMPLES_PER_BIT:   regs.samples_per_bit = cfg_data[3:0];
					CFG_SAMPLES_HIGH_ONE:  regs.samples_high_one = cfg_data[3:0];
					CFG_SAMPLES_HIGH_ZERO: regs.samples_high_zero = cfg_data[3:0];
					CFG_GAP_SAMPLES:       regs.gap_samples = cfg_data;
					CFG_TELEMETRY_REQUEST: regs.telemetry_request = cfg_data[0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (sample_q.size() == 0) begin
					report_mismatch($sformatf("result pins %0h active %0b with nothing expected",
						result.pin_levels, result.active));
				end else begin
					want_s = sample_q.pop_front();
					check_field("pin_levels", result.pin_levels, want_s.pins);
					check_field("active", result.active, want_s.active);
					check_field("done_res", result.done_res, want_s.done);
				end
			end
			if (item.valid && item.ready)
				sample_q.push_back(encode_step(item.func,
					{item.throttle_3, item.throttle_2, item.throttle_1, item.throttle_0}));
			waiting = sample_q.size();
		end
	end

endmodule

[tb/tb_dshot_frame_waveform_encoder.sv]
// top of the encoder testbench: clock, reset, register writes and item stimulus by phase
// depends on dfwe_pkg, dfwe_tb_pkg, the interfaces, dfwe_scoreboard and the encoder
module tb_dshot_frame_waveform_encoder;
	import dfwe_pkg::*;
	import dfwe_tb_pkg::*;

	typedef enum int {
		IDLE_NONE   = 0,
		IDLE_SOURCE = 1,
		IDLE_SINK   = 2,
		IDLE_BOTH   = 3
	} idle_mode_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;
	int         fails;
	int         waiting;
	int         src_idle_pct;
	int         sink_stall_pct;
	int         items_sent;
	cfg_t       cur_cfg;
	cfg_t       next_cfg;

	dfwe_in_if  item_ch ();
	dfwe_out_if result_ch ();

	dshot_frame_waveform_encoder #(.MOTORS(4)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dfwe_scoreboard chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.waiting   (waiting)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver side: stall at random on the falling edge
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		#(12 * 250000);
		$display("simulation failed");
		$finish;
	end

	function automatic int frame_len(input cfg_t c);
		return FRAME_BITS * ((c.samples_per_bit == 4'd0) ? 1 : int'(c.samples_per_bit))
			+ int'(c.gap_samples);
	endfunction

	function automatic logic [10:0] rand_throttle();
		case ($urandom_range(7))
			0: return 11'h000;
			1: return 11'h7FF;
			default: return 11'($urandom_range(2047));
		endcase
	endfunction

	function automatic logic [3:0][10:0] rand_throttles();
		return {rand_throttle(), rand_throttle(), rand_throttle(), rand_throttle()};
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.samples_per_bit = 4'($urandom_range(0, 5));
		c.samples_high_one = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
			: 4'($urandom_range(0, int'(c.samples_per_bit) + 1));
		c.samples_high_zero = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
			: 4'($urandom_range(0, int'(c.samples_per_bit) + 1));
		c.gap_samples = 8'($urandom_range(0, 6));
		c.telemetry_request = 1'($urandom_range(1));
		return c;
	endfunction

	// entered just after a falling edge; returns just after the falling edge past the transfer
	task automatic send_item(input func_t f, input logic [3:0][10:0] thr);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.func = f;
		item_ch.throttle_0 = thr[0];
		item_ch.throttle_1 = thr[1];
		item_ch.throttle_2 = thr[2];
		item_ch.throttle_3 = thr[3];
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent = items_sent + 1;
		@(negedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(FUNC_TICK, rand_throttles());
	endtask

	task automatic drain();
		item_ch.valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		cfg_wr_en = 1'b1;
		cfg_index = CFG_SAMPLES_PER_BIT;
		cfg_data = 8'(c.samples_per_bit);
		@(negedge clk);
		cfg_index = CFG_SAMPLES_HIGH_ONE;
		cfg_data = 8'(c.samples_high_one);
		@(negedge clk);
		cfg_index = CFG_SAMPLES_HIGH_ZERO;
		cfg_data = 8'(c.samples_high_zero);
		@(negedge clk);
		cfg_index = CFG_GAP_SAMPLES;
		cfg_data = c.gap_samples;
		@(negedge clk);
		cfg_index = CFG_TELEMETRY_REQUEST;
		cfg_data = 8'(c.telemetry_request);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cur_cfg = c;
	endtask

	// mostly whole frames, some cut short by a new start, some stray ticks;
	// ends with enough ticks to let any running frame finish
	task automatic random_traffic(input int budget);
		int start_count;
		int pick;
		int len;
		start_count = items_sent;
		len = frame_len(cur_cfg);
		while (items_sent - start_count < budget) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				send_item(FUNC_START, rand_throttles());
				send_ticks(len + $urandom_range(0, 3));
			end else if (pick < 90) begin
				send_item(FUNC_START, rand_throttles());
				send_ticks($urandom_range(1, len));
			end else begin
				send_ticks($urandom_range(1, 4));
			end
		end
		send_ticks(len);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			IDLE_SOURCE: begin src_idle_pct = 68; sink_stall_pct = 0;  end
			IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 68; end
			default:     begin src_idle_pct = 25; sink_stall_pct = 25; end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_TICK;
		item_ch.throttle_0 = '0;
		item_ch.throttle_1 = '0;
		item_ch.throttle_2 = '0;
		item_ch.throttle_3 = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_SAMPLES_PER_BIT;
		cfg_data = '0;
		items_sent = 0;
		set_idling(IDLE_NONE);
		cur_cfg = '{samples_per_bit: 4'd8, samples_high_one: 4'd6, samples_high_zero: 4'd3,
			gap_samples: 8'd16, telemetry_request: 1'b0};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, on the reset settings
		send_ticks(1);
		send_item(FUNC_START, {11'h2AA, 11'h555, 11'h7FF, 11'h000});
		send_ticks(9);
		// restart in the middle of a frame
		send_item(FUNC_START, {11'h555, 11'h2AA, 11'h000, 11'h7FF});
		send_ticks(4);
		send_item(FUNC_START, rand_throttles());
		send_ticks(frame_len(cur_cfg));
		send_ticks(1);

		for (int p = 1; p <= 5; p++) begin
			set_idling(idle_mode_t'(p % 4));
			case (p)
				1: next_cfg = '{samples_per_bit: 4'd15, samples_high_one: 4'd15,
					samples_high_zero: 4'd0, gap_samples: 8'd12, telemetry_request: 1'b1};
				2: next_cfg = '0;
				3: next_cfg = '{samples_per_bit: 4'd2, samples_high_one: 4'd2,
					samples_high_zero: 4'd15, gap_samples: 8'd1, telemetry_request: 1'b0};
				default: next_cfg = rand_cfg();
			endcase
			drain();
			write_cfg(next_cfg);
			if (p == 1) begin
				// one full frame at the longest bit
				send_item(FUNC_START, rand_throttles());
				send_ticks(frame_len(cur_cfg) + 2);
			end else begin
				random_traffic(45);
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fails == 0 && waiting == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/dfwe_pkg.sv
src/dfwe_in_if.sv
src/dfwe_out_if.sv
src/dfwe_in_stage.sv
src/dfwe_core.sv
src/dshot_frame_waveform_encoder.sv
src/dfwe_checker.sv
tb/dfwe_tb_pkg.sv
tb/dfwe_checker.sv
tb/tb_dshot_frame_waveform_encoder.sv
